// ===== src/mra_pkg.sv =====
`default_nettype none
package mra_pkg;

   localparam int RATCHET_PARTS = 4;
   localparam int WORD_COUNT    = 16;

   typedef enum logic [1:0] {
      KIND_LOAD_WORD    = 2'd0,
      KIND_LOAD_COUNTER = 2'd1,
      KIND_ADVANCE_ONE  = 2'd2,
      KIND_ADVANCE_TO   = 2'd3
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PLAN,
      ST_REP,
      ST_CHAIN,
      ST_INNER,
      ST_OUTER,
      ST_NEXTJ,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic         start;
      logic [255:0] key_msg;
      logic [7:0]   key_byte;
   } hmac_cmd_type;

   typedef struct packed {
      logic         done;
      logic [255:0] digest;
   } hmac_sts_type;

   localparam logic [255:0] SHA_IV = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   function automatic logic [31:0] sha_k(input logic [5:0] i);
      logic [31:0] k;
      case (i)
         6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
         6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
         6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
         6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
         6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
         6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
         default: k = 32'h0;
      endcase
      return k;
   endfunction

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

endpackage
`default_nettype wire

// ===== src/mra_sha_core.sv =====
`default_nettype none
module mra_sha_core (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [255:0] chain_in,
   input  wire logic [511:0] block_in,
   output logic              done,
   output logic [255:0]      chain_out
);

   logic [511:0] w_ff, w_in;
   logic [255:0] s_ff, s_in;
   logic [255:0] c_ff, c_in;
   logic [5:0]   rnd_ff, rnd_in;
   logic         run_ff, run_in;
   logic         done_ff, done_in;

   logic [31:0] a, b, c, d, e, f, g, h, t1, t2, w0, s0, s1, wn;
   logic [255:0] nxt, fin;

   always_comb begin
      {a, b, c, d, e, f, g, h} = s_ff;
      w0 = w_ff[511:480];
      t1 = h + (mra_pkg::rotr(e, 6) ^ mra_pkg::rotr(e, 11) ^ mra_pkg::rotr(e, 25))
           + ((e & f) ^ (~e & g)) + mra_pkg::sha_k(rnd_ff) + w0;
      t2 = (mra_pkg::rotr(a, 2) ^ mra_pkg::rotr(a, 13) ^ mra_pkg::rotr(a, 22))
           + ((a & b) ^ (a & c) ^ (b & c));
      s0 = mra_pkg::rotr(w_ff[479:448], 7) ^ mra_pkg::rotr(w_ff[479:448], 18)
           ^ (w_ff[479:448] >> 3);
      s1 = mra_pkg::rotr(w_ff[63:32], 17) ^ mra_pkg::rotr(w_ff[63:32], 19)
           ^ (w_ff[63:32] >> 10);
      wn = w0 + s0 + w_ff[223:192] + s1;
      nxt = {t1 + t2, a, b, c, d + t1, e, f, g};
      for (int i = 0; i < 8; i++) begin
         fin[255-32*i -: 32] = c_ff[255-32*i -: 32] + nxt[255-32*i -: 32];
      end
      w_in = w_ff; s_in = s_ff; c_in = c_ff; rnd_in = rnd_ff;
      run_in = run_ff; done_in = 1'b0;
      if (start && !run_ff) begin
         w_in = block_in; s_in = chain_in; c_in = chain_in;
         rnd_in = '0; run_in = 1'b1;
      end else if (run_ff) begin
         w_in = {w_ff[479:0], wn};
         s_in = nxt;
         rnd_in = rnd_ff + 6'd1;
         if (rnd_ff == 6'd63) begin
            run_in = 1'b0; done_in = 1'b1; c_in = fin;
         end
      end
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in; s_ff <= s_in; c_ff <= c_in; rnd_ff <= rnd_in;
      if (reset) begin
         run_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         run_ff <= run_in; done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign chain_out = c_ff;

endmodule
`default_nettype wire

// ===== src/mra_hmac.sv =====
`default_nettype none
module mra_hmac (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire mra_pkg::hmac_cmd_type cmd,
   output mra_pkg::hmac_sts_type      sts
);

   logic [1:0]   step_ff, step_in;
   logic         busy_ff, busy_in;
   logic [255:0] msg_ff, msg_in, inner_ff, inner_in;
   logic [7:0]   key_ff, key_in;
   logic         done_ff, done_in;
   logic         core_start, core_done;
   logic [255:0] core_chain, core_out;
   logic [511:0] core_block, pad;

   mra_sha_core u_core (
      .clock(clock), .reset(reset), .start(core_start), .chain_in(core_chain),
      .block_in(core_block), .done(core_done), .chain_out(core_out));

   always_comb begin
      pad = {(step_ff[1] ? 8'h5c : 8'h36) ^ key_ff, {63{step_ff[1] ? 8'h5c : 8'h36}}};
      step_in = step_ff; busy_in = busy_ff; msg_in = msg_ff; inner_in = inner_ff;
      key_in = key_ff; done_in = 1'b0;
      core_start = 1'b0; core_chain = mra_pkg::SHA_IV; core_block = pad;
      if (!busy_ff) begin
         if (cmd.start) begin
            busy_in = 1'b1; step_in = 2'd0; msg_in = cmd.key_msg; key_in = cmd.key_byte;
            core_start = 1'b1;
            core_block = {8'h36 ^ cmd.key_byte, {63{8'h36}}};
         end
      end else if (core_done) begin
         step_in = step_ff + 2'd1;
         core_start = 1'b1;
         case (step_ff)
            2'd0: begin
               core_chain = core_out;
               core_block = {msg_ff, 8'h80, 232'h0, 16'h0300};
            end
            2'd1: begin
               inner_in = core_out;
               core_block = {8'h5c ^ key_ff, {63{8'h5c}}};
            end
            2'd2: begin
               core_chain = core_out;
               core_block = {inner_ff, 8'h80, 232'h0, 16'h0300};
            end
            default: begin
               core_start = 1'b0; busy_in = 1'b0; done_in = 1'b1; inner_in = core_out;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      msg_ff <= msg_in; inner_ff <= inner_in; key_ff <= key_in;
      step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign sts = {done_ff, inner_ff};

endmodule
`default_nettype wire

// ===== src/megolm_ratchet_advance_unit.sv =====
`default_nettype none
// channel   ports                                            handshake
// request   req_kind req_word_index req_word_value req_counter_value  start & !busy
// response  rsp_index rsp_word rsp_counter rsp_last          rsp_valid
// Each rekey runs four SHA-256 compressions of 64 rounds on one shared round
// unit. Advance by one takes up to 4 rekeys plus 16 output words.
// Advance to takes at most 1027 rekeys (a full wrap of part zero, then 255
// steps at each lower byte).
// Loads never raise busy. Reset is synchronous and clears counter and ratchet.
// Results cannot be stalled; busy stays high until the last word is out.
module megolm_ratchet_advance_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_kind,
   input  wire logic [3:0]  req_word_index,
   input  wire logic [63:0] req_word_value,
   input  wire logic [31:0] req_counter_value,
   output logic             rsp_valid,
   output logic [3:0]       rsp_index,
   output logic [63:0]      rsp_word,
   output logic [31:0]      rsp_counter,
   output logic             rsp_last
);

   mra_pkg::state_type st_ff, st_in;
   logic [255:0] part_ff [mra_pkg::RATCHET_PARTS];
   logic [255:0] part_in [mra_pkg::RATCHET_PARTS];
   logic [31:0]  cnt_ff, cnt_in, tgt_ff, tgt_in;
   logic [1:0]   j_ff, j_in, k_ff, k_in, src_ff, src_in;
   logic [8:0]   steps_ff, steps_in;
   logic         one_ff, one_in;
   logic [3:0]   idx_ff, idx_in;
   logic         wait_ff, wait_in;
   mra_pkg::hmac_cmd_type cmd;
   mra_pkg::hmac_sts_type sts;
   logic [31:0]  inc;
   logic [1:0]   hsel;
   logic [4:0]   sh;
   logic [7:0]   diff;

   mra_hmac u_hmac (.clock(clock), .reset(reset), .cmd(cmd), .sts(sts));

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= mra_pkg::ST_IDLE; cnt_ff <= '0;
         for (int i = 0; i < mra_pkg::RATCHET_PARTS; i++) part_ff[i] <= '0;
      end else begin
         st_ff <= st_in; cnt_ff <= cnt_in;
         for (int i = 0; i < mra_pkg::RATCHET_PARTS; i++) part_ff[i] <= part_in[i];
      end
      tgt_ff <= tgt_in; j_ff <= j_in; k_ff <= k_in; src_ff <= src_in;
      steps_ff <= steps_in; one_ff <= one_in; idx_ff <= idx_in; wait_ff <= wait_in;
   end

   always_comb begin
      st_in = st_ff; cnt_in = cnt_ff; tgt_in = tgt_ff; j_in = j_ff; k_in = k_ff;
      src_in = src_ff; steps_in = steps_ff; one_in = one_ff; idx_in = idx_ff;
      wait_in = wait_ff;
      for (int i = 0; i < mra_pkg::RATCHET_PARTS; i++) part_in[i] = part_ff[i];
      cmd.start = 1'b0; cmd.key_msg = part_ff[src_ff]; cmd.key_byte = {6'd0, k_ff};
      inc = cnt_ff + 32'd1;
      hsel = (inc[23:0] == 24'd0) ? 2'd0 : (inc[15:0] == 16'd0) ? 2'd1 :
             (inc[7:0] == 8'd0) ? 2'd2 : 2'd3;
      sh = 5'(8 * (3 - 32'(j_ff)));
      diff = 8'((tgt_ff >> sh) - (cnt_ff >> sh));
      case (st_ff)
         mra_pkg::ST_IDLE: begin
            if (start) begin
               case (mra_pkg::kind_type'(req_kind))
                  mra_pkg::KIND_LOAD_WORD:
                     part_in[req_word_index[3:2]][255-64*req_word_index[1:0] -: 64] =
                        req_word_value;
                  mra_pkg::KIND_LOAD_COUNTER: cnt_in = req_counter_value;
                  mra_pkg::KIND_ADVANCE_ONE: begin
                     one_in = 1'b1; st_in = mra_pkg::ST_PLAN;
                  end
                  default: begin
                     one_in = 1'b0; tgt_in = req_counter_value; j_in = 2'd0;
                     st_in = mra_pkg::ST_PLAN;
                  end
               endcase
            end
         end
         mra_pkg::ST_PLAN: begin
            wait_in = 1'b0;
            if (one_ff) begin
               cnt_in = inc; src_in = hsel; k_in = 2'd3; j_in = hsel;
               st_in = mra_pkg::ST_CHAIN;
            end else begin
               src_in = j_ff;
               if (diff == 8'd0 && !(tgt_ff < cnt_ff)) st_in = mra_pkg::ST_NEXTJ;
               else begin
                  steps_in = (diff == 8'd0) ? 9'h100 : {1'b0, diff};
                  k_in = j_ff; st_in = mra_pkg::ST_REP;
               end
            end
         end
         mra_pkg::ST_REP: begin
            if (steps_ff <= 9'd1) begin
               k_in = 2'd3; st_in = mra_pkg::ST_CHAIN;
            end else if (!wait_ff) begin
               cmd.start = 1'b1; wait_in = 1'b1;
            end else if (sts.done) begin
               part_in[j_ff] = sts.digest; wait_in = 1'b0; steps_in = steps_ff - 9'd1;
            end
         end
         mra_pkg::ST_CHAIN: begin
            if (!wait_ff) begin
               cmd.start = 1'b1; wait_in = 1'b1;
            end else if (sts.done) begin
               part_in[k_ff] = sts.digest; wait_in = 1'b0;
               if (k_ff == j_ff) begin
                  if (one_ff) begin
                     idx_in = '0; st_in = mra_pkg::ST_EMIT;
                  end else begin
                     cnt_in = tgt_ff & (32'hFFFFFFFF << sh); st_in = mra_pkg::ST_NEXTJ;
                  end
               end else k_in = k_ff - 2'd1;
            end
         end
         mra_pkg::ST_NEXTJ: begin
            if (j_ff == 2'd3) begin
               idx_in = '0; st_in = mra_pkg::ST_EMIT;
            end else begin
               j_in = j_ff + 2'd1; st_in = mra_pkg::ST_PLAN;
            end
         end
         mra_pkg::ST_EMIT: begin
            idx_in = idx_ff + 4'd1;
            if (idx_ff == 4'd15) st_in = mra_pkg::ST_IDLE;
         end
         default: st_in = mra_pkg::ST_IDLE;
      endcase
   end

   assign busy        = (st_ff != mra_pkg::ST_IDLE);
   assign rsp_valid   = (st_ff == mra_pkg::ST_EMIT);
   assign rsp_index   = idx_ff;
   assign rsp_word    = part_ff[idx_ff[3:2]][255-64*idx_ff[1:0] -: 64];
   assign rsp_counter = cnt_ff;
   assign rsp_last    = rsp_valid && (idx_ff == 4'd15);

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_last |=> !rsp_valid) else $error("response after last word");
   a_idx_seq: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |=> (rsp_valid && rsp_index == $past(rsp_index) + 4'd1))
      else $error("response index out of sequence");
   a_busy_resp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("response while idle");

endmodule
`default_nettype wire
